// ===== sv/ffbu_pkg.sv =====
// ffbu_pkg: shared widths, constants, register indexes and the
// controller-to-datapath command/status types of the flow field upsampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffbu_pkg;

	localparam int SRC_W_MAX = 64;
	localparam int SRC_H_MAX = 64;
	localparam int DST_MAX   = 256;

	localparam int COL_W  = $clog2(SRC_W_MAX);
	localparam int ROW_W  = $clog2(SRC_H_MAX);
	localparam int SW_W   = 7;
	localparam int DW_W   = 9;
	localparam int QI_W   = 8;
	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int D_W    = DW_W + 1;
	localparam int CELL_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int Q_W    = CELL_W + FRAC_W;
	localparam int SRC_MAX = (SRC_W_MAX > SRC_H_MAX) ? SRC_W_MAX : SRC_H_MAX;
	localparam int N_W    = $clog2((2 * DST_MAX - 1) * SRC_MAX);
	localparam int DIVD_W = N_W + FRAC_W;
	localparam int CNT_W  = $clog2(Q_W);
	localparam int ADDR_W = 1 + ROW_W + COL_W;
	localparam int DEPTH  = 2 * SRC_W_MAX * SRC_H_MAX;
	localparam int APB_AW = 4;
	localparam int STEP_W = 4;
	localparam int LAST_STEP = 9;

	typedef enum logic [1:0] {
		REG_SRC_W = 2'd0,
		REG_SRC_H = 2'd1,
		REG_DST_W = 2'd2,
		REG_DST_H = 2'd3
	} ffbu_reg_t;

	typedef struct packed {
		logic       div_start;
		logic       prep;
		logic       rd_en;
		logic [1:0] corner;   // bit0: right column, bit1: lower row
		logic       plane;
		logic       cap_a;
		logic       cap_top;
		logic       cap_bot;
		logic       cap_diff;
		logic       cap_pl;
		logic       cap_ph;
		logic       cap_sum;
		logic       cap_res;
		logic       publish;
	} ffbu_cmd_t;

	typedef struct packed {
		logic div_done;
	} ffbu_stat_t;

endpackage
`default_nettype wire

// ===== sv/ffbu_if.sv =====
// ffbu_query_if / ffbu_result_if: valid/ready channels of the upsampler.
// Depends on ffbu_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ffbu_query_if import ffbu_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic                     plane;
	logic [COL_W-1:0]         load_column;
	logic [ROW_W-1:0]         load_row;
	logic signed [DATA_W-1:0] sample_value;
	logic [QI_W-1:0]          query_column;
	logic [QI_W-1:0]          query_row;
	modport source (output valid, mode, plane, load_column, load_row, sample_value,
		query_column, query_row, input ready);
	modport sink (input valid, mode, plane, load_column, load_row, sample_value,
		query_column, query_row, output ready);
endinterface

interface ffbu_result_if import ffbu_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] flow_u;
	logic signed [DATA_W-1:0] flow_v;
	modport source (output valid, flow_u, flow_v, input ready);
	modport sink (input valid, flow_u, flow_v, output ready);
endinterface
`default_nettype wire

// ===== sv/flow_field_bilinear_upsampler.sv =====
// flow_field_bilinear_upsampler: top level with APB register file.
// Depends on ffbu_pkg, ffbu_if, ffbu_ctrl, ffbu_datapath.
//
// Usage:
//   query channel (valid/ready): mode 0 writes one u or v source sample into
//   the store and returns nothing; mode 1 asks for destination pixel
//   (query_column, query_row) and returns one transaction on result.
//   result channel (valid/ready): flow_u, flow_v, doubled bilinear samples,
//   Q16.16, saturated.
//   APB port: source/target width/height at byte addresses 0, 4, 8, 12;
//   write only while the block is idle.
// Sequence: a query runs coordinate division (22 quotient bits, x and y in
//   parallel), forms the corner indexes, does store reads and arithmetic for
//   the two planes (one read port), publishes and returns to idle; no load
//   or new query is taken before the block is idle again.
// Reset: clears control state and sets sizes to 64, 64, 128, 128; the store
//   is not cleared, every entry read must have been loaded first.
// Stall: a finished result waits in the output register; loads and a new
//   query are still taken, and a second result waits until the first is taken.
`timescale 1ns / 1ps
`default_nettype none
module flow_field_bilinear_upsampler import ffbu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	ffbu_query_if.sink             query,
	ffbu_result_if.source          result
);
	logic [SW_W-1:0] src_w_q, src_h_q;
	logic [DW_W-1:0] dst_w_q, dst_h_q;
	logic            wr_en;
	ffbu_cmd_t       cmd;
	ffbu_stat_t      stat;
	ffbu_reg_t       sel;

	assign pready = 1'b1;
	assign sel = ffbu_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SW_W'(64);
			src_h_q <= SW_W'(64);
			dst_w_q <= DW_W'(128);
			dst_h_q <= DW_W'(128);
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				REG_SRC_W: src_w_q <= pwdata[SW_W-1:0];
				REG_SRC_H: src_h_q <= pwdata[SW_W-1:0];
				REG_DST_W: dst_w_q <= pwdata[DW_W-1:0];
				REG_DST_H: dst_h_q <= pwdata[DW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_SRC_W: prdata = 32'(src_w_q);
			REG_SRC_H: prdata = 32'(src_h_q);
			REG_DST_W: prdata = 32'(dst_w_q);
			REG_DST_H: prdata = 32'(dst_h_q);
			default: prdata = '0;
		endcase
	end

	ffbu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(query.valid), .in_mode(query.mode), .in_ready(query.ready),
		.out_valid(result.valid), .out_ready(result.ready),
		.wr_en(wr_en), .cmd(cmd), .stat(stat)
	);

	ffbu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_sw(src_w_q), .cfg_sh(src_h_q), .cfg_dw(dst_w_q), .cfg_dh(dst_h_q),
		.wr_en(wr_en), .plane(query.plane), .load_column(query.load_column),
		.load_row(query.load_row), .sample_value(query.sample_value),
		.query_column(query.query_column), .query_row(query.query_row),
		.flow_u(result.flow_u), .flow_v(result.flow_v)
	);
endmodule
`default_nettype wire

// ===== sv/ffbu_div.sv =====
// ffbu_div: restoring divider, one quotient bit per cycle.
// Depends on ffbu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffbu_div import ffbu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [D_W-1:0]    divisor,
	output logic                   done,
	output logic [Q_W-1:0]         quotient
);
	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q, dvs_q;
	logic [Q_W-1:0]   num_q;
	logic [D_W:0]     trial;
	logic             ge;

	always_comb begin
		trial = {rem_q, num_q[Q_W-1]};
		ge = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(Q_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= D_W'(dividend[DIVD_W-1:Q_W]);
			num_q <= dividend[Q_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? D_W'(trial - {1'b0, dvs_q}) : trial[D_W-1:0];
			num_q <= {num_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = num_q;
endmodule
`default_nettype wire

// ===== sv/ffbu_datapath.sv =====
// ffbu_datapath: flow store, coordinate mapping with two dividers,
// bilinear arithmetic and result registers. Depends on ffbu_pkg, ffbu_div.
`timescale 1ns / 1ps
`default_nettype none
module ffbu_datapath import ffbu_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ffbu_cmd_t                cmd,
	output ffbu_stat_t                    stat,
	input  wire logic [SW_W-1:0]          cfg_sw,
	input  wire logic [SW_W-1:0]          cfg_sh,
	input  wire logic [DW_W-1:0]          cfg_dw,
	input  wire logic [DW_W-1:0]          cfg_dh,
	input  wire logic                     wr_en,
	input  wire logic                     plane,
	input  wire logic [COL_W-1:0]         load_column,
	input  wire logic [ROW_W-1:0]         load_row,
	input  wire logic signed [DATA_W-1:0] sample_value,
	input  wire logic [QI_W-1:0]          query_column,
	input  wire logic [QI_W-1:0]          query_row,
	output logic signed [DATA_W-1:0]      flow_u,
	output logic signed [DATA_W-1:0]      flow_v
);
	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	logic [SW_W-1:0]   sw_e, sh_e;
	logic [DW_W-1:0]   dw_e, dh_e;
	logic [QI_W-1:0]   ix_e, iy_e;
	logic [2*DW_W-1:0] px, py;
	logic signed [2*DW_W:0] nx, ny;
	logic [D_W-1:0]    dx, dy;
	logic [N_W-1:0]    nnx, nny;
	logic              negx_q, negy_q, xdone, ydone;
	logic [Q_W-1:0]    qx, qy;
	logic [CELL_W-1:0] cx, cy;
	logic [SW_W-1:0]   cx1, cy1;

	logic [COL_W-1:0]  x0_q, x1_q;
	logic [ROW_W-1:0]  y0_q, y1_q;
	logic [FRAC_W-1:0] fx_q, fy_q;
	logic [ADDR_W-1:0] raddr;

	logic signed [DATA_W-1:0] a_q;
	logic signed [DATA_W:0]   hdiff;
	logic signed [49:0]       hprod, hval, top_q, bot_q;
	logic signed [50:0]       diff_q;
	logic signed [42:0]       pl_q, ph_q;
	logic signed [67:0]       sum_q;
	logic signed [36:0]       rsh;
	logic signed [DATA_W-1:0] sat, res_u_q, res_v_q, flow_u_q, flow_v_q;

	always_comb begin
		sw_e = (cfg_sw == '0) ? SW_W'(1) : (cfg_sw > SW_W'(SRC_W_MAX)) ? SW_W'(SRC_W_MAX) : cfg_sw;
		sh_e = (cfg_sh == '0) ? SW_W'(1) : (cfg_sh > SW_W'(SRC_H_MAX)) ? SW_W'(SRC_H_MAX) : cfg_sh;
		dw_e = (cfg_dw == '0) ? DW_W'(1) : (cfg_dw > DW_W'(DST_MAX)) ? DW_W'(DST_MAX) : cfg_dw;
		dh_e = (cfg_dh == '0) ? DW_W'(1) : (cfg_dh > DW_W'(DST_MAX)) ? DW_W'(DST_MAX) : cfg_dh;
		ix_e = (DW_W'(query_column) > dw_e - 1'b1) ? QI_W'(dw_e - 1'b1) : query_column;
		iy_e = (DW_W'(query_row) > dh_e - 1'b1) ? QI_W'(dh_e - 1'b1) : query_row;
		px = (2*DW_W)'({ix_e, 1'b1}) * (2*DW_W)'(sw_e);
		py = (2*DW_W)'({iy_e, 1'b1}) * (2*DW_W)'(sh_e);
		dx = {dw_e, 1'b0};
		dy = {dh_e, 1'b0};
		nx = $signed({1'b0, px}) - $signed((2*DW_W+1)'(dw_e));
		ny = $signed({1'b0, py}) - $signed((2*DW_W+1)'(dh_e));
		nnx = nx[2*DW_W] ? N_W'(nx + $signed((2*DW_W+1)'(dx))) : N_W'(nx);
		nny = ny[2*DW_W] ? N_W'(ny + $signed((2*DW_W+1)'(dy))) : N_W'(ny);
		cx = qx[Q_W-1:FRAC_W];
		cy = qy[Q_W-1:FRAC_W];
		cx1 = SW_W'(cx) + 1'b1;
		cy1 = SW_W'(cy) + 1'b1;
	end

	ffbu_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend({nnx, FRAC_W'(0)}), .divisor(dx), .done(xdone), .quotient(qx)
	);

	ffbu_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend({nny, FRAC_W'(0)}), .divisor(dy), .done(ydone), .quotient(qy)
	);

	assign stat.div_done = xdone && ydone;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			negx_q <= nx[2*DW_W];
			negy_q <= ny[2*DW_W];
		end
		if (cmd.prep) begin
			// x wraps around, y clamps at first and last row
			x0_q <= negx_q ? COL_W'(sw_e - 1'b1) : COL_W'(cx);
			x1_q <= (negx_q || cx1 == sw_e) ? '0 : COL_W'(cx1);
			y0_q <= negy_q ? '0 : ROW_W'(cy);
			y1_q <= negy_q ? '0 : (cy1 >= sh_e) ? ROW_W'(sh_e - 1'b1) : ROW_W'(cy1);
			fx_q <= qx[FRAC_W-1:0];
			fy_q <= qy[FRAC_W-1:0];
		end
	end

	assign raddr = {cmd.plane, cmd.corner[1] ? y1_q : y0_q, cmd.corner[0] ? x1_q : x0_q};

	always_ff @(posedge clk) begin
		if (wr_en) mem[{plane, load_row, load_column}] <= sample_value;
		if (cmd.rd_en) rdata_q <= mem[raddr];
	end

	always_comb begin
		hdiff = (DATA_W+1)'(rdata_q) - (DATA_W+1)'(a_q);
		hprod = 50'($signed({1'b0, fx_q})) * 50'(hdiff);
		hval = (50'(a_q) <<< FRAC_W) + hprod;
		rsh = sum_q[67:31];
		if (rsh[36:31] != {6{rsh[31]}})
			sat = rsh[36] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		else
			sat = rsh[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) a_q <= rdata_q;
		if (cmd.cap_top) top_q <= hval;
		if (cmd.cap_bot) bot_q <= hval;
		if (cmd.cap_diff) diff_q <= 51'(bot_q) - 51'(top_q);
		if (cmd.cap_pl) pl_q <= 43'($signed({1'b0, fy_q})) * 43'($signed({1'b0, diff_q[24:0]}));
		if (cmd.cap_ph) ph_q <= 43'($signed({1'b0, fy_q})) * 43'($signed(diff_q[50:25]));
		if (cmd.cap_sum) sum_q <= (68'(top_q) <<< FRAC_W) + (68'(ph_q) <<< 25) + 68'(pl_q);
		if (cmd.cap_res && !cmd.plane) res_u_q <= sat;
		if (cmd.cap_res && cmd.plane) res_v_q <= sat;
		if (cmd.publish) begin
			flow_u_q <= res_u_q;
			flow_v_q <= res_v_q;
		end
	end

	assign flow_u = flow_u_q;
	assign flow_v = flow_v_q;
endmodule
`default_nettype wire

// ===== sv/ffbu_ctrl.sv =====
// ffbu_ctrl: sequencer of the upsampler; issues datapath commands and
// owns the channel handshakes. Depends on ffbu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffbu_ctrl import ffbu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_mode,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            wr_en,
	output ffbu_cmd_t       cmd,
	input  wire ffbu_stat_t stat
);
	typedef enum logic [2:0] {S_IDLE, S_DIV, S_PREP, S_CALC, S_PUB} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              plane_q, out_valid_q, in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign wr_en = in_fire && !in_mode;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.div_start = in_fire && in_mode;
		cmd.prep = (state_q == S_PREP);
		cmd.plane = plane_q;
		cmd.corner = step_q[1:0];
		cmd.publish = (state_q == S_PUB) && (!out_valid_q || out_ready);
		if (state_q == S_CALC) begin
			unique case (step_q)
				4'd0: cmd.rd_en = 1'b1;
				4'd1: begin cmd.rd_en = 1'b1; cmd.cap_a = 1'b1; end
				4'd2: begin cmd.rd_en = 1'b1; cmd.cap_top = 1'b1; end
				4'd3: begin cmd.rd_en = 1'b1; cmd.cap_a = 1'b1; end
				4'd4: cmd.cap_bot = 1'b1;
				4'd5: cmd.cap_diff = 1'b1;
				4'd6: cmd.cap_pl = 1'b1;
				4'd7: cmd.cap_ph = 1'b1;
				4'd8: cmd.cap_sum = 1'b1;
				4'd9: cmd.cap_res = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			plane_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_fire && in_mode) state_q <= S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_PREP;
				S_PREP: begin
					state_q <= S_CALC;
					step_q <= '0;
					plane_q <= 1'b0;
				end
				S_CALC: begin
					if (step_q == STEP_W'(LAST_STEP)) begin
						step_q <= '0;
						plane_q <= 1'b1;
						if (plane_q) state_q <= S_PUB;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_PUB: begin
					if (cmd.publish) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> state_q == S_DIV)
		else $error("divider finished outside division phase");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_mode) |=> state_q == S_DIV)
		else $error("query transaction did not start division");
	a_calc_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CALC |-> step_q <= STEP_W'(LAST_STEP))
		else $error("step counter out of range");
endmodule
`default_nettype wire
